// ----- hw/rtl/ssoi_pkg.sv -----
// ============================================================================
// ssoi_pkg - shared types and constants for the skid-steer odometry integrator
// Word layouts, fixed widths, register indexes and the CORDIC angle table.
// ============================================================================
package ssoi_pkg;

    // Fixed field widths
    localparam int DIST_W    = 24;   // one wheel travel
    localparam int SIDE_W    = 25;   // sum of two wheels on one side
    localparam int SUM_W     = 26;   // sum of all four wheels
    localparam int MUL_A_W   = 27;   // signed multiplier operand
    localparam int GAIN_W    = 32;   // gain registers
    localparam int LIMIT_W   = 24;   // jump limit register
    localparam int HEAD_W    = 32;   // binary angle
    localparam int POS_IN_W  = 40;   // position fields on the ports
    localparam int HPROD_W   = 60;   // heading gain product
    localparam int KPROD_W   = 60;   // prescale product
    localparam int KSHIFT    = 18;   // prescale product to CORDIC start value
    localparam int CORDIC_W  = 42;   // CORDIC x and y datapath
    localparam int DX_W      = CORDIC_W + 1 - 16; // rounded step in 2^-16 m
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    // Default parameter values
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int POS_BITS_DEF      = 40;
    localparam int CORDIC_MAX        = 24;

    // Limit CORDIC gain 0.6072529350 in Q32
    localparam logic [31:0] GAIN_K = 32'd2608131496;

    // Register reset values
    localparam logic [GAIN_W-1:0]  TURN_GAIN_RST  = 32'd621422978;
    localparam logic [GAIN_W-1:0]  PIVOT_GAIN_RST = 32'd878825697;
    localparam logic [LIMIT_W-1:0] JUMP_LIMIT_RST = 24'd6554;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIVOT_GAIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_LIMIT = 2'd2;

    // Input word
    typedef struct packed {
        logic              func;
        logic [DIST_W-1:0] left_front_dist;
        logic [DIST_W-1:0] left_back_dist;
        logic [DIST_W-1:0] right_front_dist;
        logic [DIST_W-1:0] right_back_dist;
        logic              pivot_mode;
        logic [POS_IN_W-1:0] new_x;
        logic [POS_IN_W-1:0] new_y;
        logic [HEAD_W-1:0] new_heading;
    } ssoi_sample_t;

    // Result word
    typedef struct packed {
        logic [POS_IN_W-1:0] pos_x;
        logic [POS_IN_W-1:0] pos_y;
        logic [HEAD_W-1:0]   heading;
        logic                jump_flag;
    } ssoi_pose_t;

    // Configuration registers
    typedef struct packed {
        logic [GAIN_W-1:0]  turn_gain;
        logic [GAIN_W-1:0]  pivot_gain;
        logic [LIMIT_W-1:0] jump_limit;
    } ssoi_cfg_t;

    // Side data that rides along the rotation chain
    typedef struct packed {
        logic                rev;      // pose revision word
        logic [HEAD_W-1:0]   heading;  // heading after this word
        logic [POS_IN_W-1:0] new_x;
        logic [POS_IN_W-1:0] new_y;
    } ssoi_tag_t;

    // Word passed from cell to cell
    typedef struct packed {
        logic [CORDIC_W-1:0] x;
        logic [CORDIC_W-1:0] y;
        logic [HEAD_W-1:0]   z;
        ssoi_tag_t           tag;
    } ssoi_cell_t;

    // atan(2^-i) in binary-angle units
    function automatic logic [HEAD_W-1:0] ssoi_atan(input int idx);
        logic [HEAD_W-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ----- hw/rtl/ssoi_front.sv -----
// ============================================================================
// ssoi_front - wheel sums, heading update and CORDIC prescale
// Three registered stages: gain multiply, heading accumulate, fold and
// multiply by the CORDIC gain. Feeds the first rotation cell.
// ============================================================================
module ssoi_front
    import ssoi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  ssoi_cfg_t    cfg,
    input  logic         up_valid,
    input  ssoi_sample_t up_word,
    output logic         up_ready,
    output logic         dn_valid,
    output ssoi_cell_t   dn_word,
    input  logic         dn_ready
);

    // Stage 1: gain product
    logic                       v1_reg;
    logic signed [HPROD_W-1:0]  prod1_reg, prod1_next;
    logic                       neg1_reg, neg1_next;
    logic signed [SUM_W-1:0]    s1_reg, s1_next;
    ssoi_tag_t                  tag1_reg, tag1_next;

    // Stage 2: heading
    logic                       v2_reg;
    logic signed [SUM_W-1:0]    s2_reg;
    logic [HEAD_W-1:0]          hold2_reg;
    ssoi_tag_t                  tag2_reg, tag2_next;
    logic [HEAD_W-1:0]          head_acc_reg, head_acc_next;

    // Stage 3: prescale product
    logic                       v3_reg;
    logic signed [KPROD_W-1:0]  kprod3_reg, kprod3_next;
    logic [HEAD_W-1:0]          z3_reg, z3_next;
    ssoi_tag_t                  tag3_reg;

    logic r1, r2, r3;

    // Ready chain: a stage takes a word when empty or when it moves on
    assign r3       = !v3_reg || dn_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign up_ready = r1;

    // Side sums and one gain multiply
    always_comb
    begin
        logic signed [SIDE_W-1:0]  sl, sr;
        logic signed [SUM_W-1:0]   sl_w, sr_w, diff;
        logic [SUM_W-1:0]          abs_l, abs_r, mag;
        logic signed [MUL_A_W-1:0] mul_a;
        logic signed [GAIN_W:0]    gain;
        sl = SIDE_W'($signed(up_word.left_front_dist))
           + SIDE_W'($signed(up_word.left_back_dist));
        sr = SIDE_W'($signed(up_word.right_front_dist))
           + SIDE_W'($signed(up_word.right_back_dist));
        sl_w = SUM_W'(sl);
        sr_w = SUM_W'(sr);
        diff = sr_w - sl_w;
        abs_l = sl_w[SUM_W-1] ? SUM_W'(-sl_w) : SUM_W'(sl_w);
        abs_r = sr_w[SUM_W-1] ? SUM_W'(-sr_w) : SUM_W'(sr_w);
        mag   = abs_l + abs_r;
        if (up_word.pivot_mode)
        begin
            mul_a = $signed({1'b0, mag});
            gain  = $signed({1'b0, cfg.pivot_gain});
        end
        else
        begin
            mul_a = MUL_A_W'(diff);
            gain  = $signed({1'b0, cfg.turn_gain});
        end
        prod1_next = HPROD_W'(mul_a) * HPROD_W'(gain);
        neg1_next  = up_word.pivot_mode && sr[SIDE_W-1];
        s1_next    = sl_w + sr_w;
        tag1_next.rev     = up_word.func;
        tag1_next.heading = up_word.new_heading;
        tag1_next.new_x   = up_word.new_x;
        tag1_next.new_y   = up_word.new_y;
    end

    // Round the product to a heading step and advance the heading
    always_comb
    begin
        logic signed [HPROD_W-1:0] hsum;
        logic [HEAD_W-1:0]         dh;
        hsum = prod1_reg + HPROD_W'(65536);
        dh   = hsum[17 +: HEAD_W];
        if (neg1_reg)
        begin
            dh = HEAD_W'(0) - dh;
        end
        head_acc_next = tag1_reg.rev ? tag1_reg.heading : head_acc_reg + dh;
        tag2_next = tag1_reg;
        tag2_next.heading = head_acc_next;
    end

    // Fold the old heading into the right half plane and prescale
    always_comb
    begin
        logic                      fold;
        logic signed [MUL_A_W-1:0] sf;
        fold = hold2_reg[HEAD_W-1] ^ hold2_reg[HEAD_W-2];
        sf   = fold ? -MUL_A_W'(s2_reg) : MUL_A_W'(s2_reg);
        z3_next = fold ? {~hold2_reg[HEAD_W-1], hold2_reg[HEAD_W-2:0]} : hold2_reg;
        kprod3_next = KPROD_W'(sf) * KPROD_W'($signed({1'b0, GAIN_K}));
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= up_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Heading state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_acc_reg <= '0;
        end
        else if (r2 && v1_reg)
        begin
            head_acc_reg <= head_acc_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (r1 && up_valid)
        begin
            prod1_reg <= prod1_next;
            neg1_reg  <= neg1_next;
            s1_reg    <= s1_next;
            tag1_reg  <= tag1_next;
        end
        if (r2 && v1_reg)
        begin
            s2_reg    <= s1_reg;
            hold2_reg <= head_acc_reg;
            tag2_reg  <= tag2_next;
        end
        if (r3 && v2_reg)
        begin
            kprod3_reg <= kprod3_next;
            z3_reg     <= z3_next;
            tag3_reg   <= tag2_reg;
        end
    end

    // Start value for the rotation chain
    assign dn_valid  = v3_reg;
    assign dn_word.x = kprod3_reg[KSHIFT +: CORDIC_W];
    assign dn_word.y = '0;
    assign dn_word.z = z3_reg;
    assign dn_word.tag = tag3_reg;

endmodule

// ----- hw/rtl/ssoi_cordic_cell.sv -----
// ============================================================================
// ssoi_cordic_cell - one CORDIC rotation stage
// Rotates x and y by plus or minus atan(2^-IDX) toward zero residual angle
// and hands the word to the next cell.
// ============================================================================
module ssoi_cordic_cell
    import ssoi_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       up_valid,
    input  ssoi_cell_t up_word,
    output logic       up_ready,
    output logic       dn_valid,
    output ssoi_cell_t dn_word,
    input  logic       dn_ready
);

    localparam logic [HEAD_W-1:0] Atan = ssoi_atan(IDX);

    logic       valid_reg;
    ssoi_cell_t word_reg, word_next;

    assign up_ready = !valid_reg || dn_ready;

    // Rotate toward zero angle
    always_comb
    begin
        logic signed [CORDIC_W-1:0] x_in, y_in, xs, ys;
        x_in = up_word.x;
        y_in = up_word.y;
        xs   = x_in >>> IDX;
        ys   = y_in >>> IDX;
        word_next = up_word;
        if (!up_word.z[HEAD_W-1])
        begin
            word_next.x = x_in - ys;
            word_next.y = y_in + xs;
            word_next.z = up_word.z - Atan;
        end
        else
        begin
            word_next.x = x_in + ys;
            word_next.y = y_in - xs;
            word_next.z = up_word.z + Atan;
        end
    end

    // Hold or advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            word_reg <= word_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_word  = word_reg;

endmodule

// ----- hw/rtl/ssoi_pos.sv -----
// ============================================================================
// ssoi_pos - step rounding, saturating position accumulate or revision overwrite
// Rounds the rotated step to 2^-16 m, adds it to the pose with saturation,
// raises the jump flag and holds the result word for the output channel.
// ============================================================================
module ssoi_pos
    import ssoi_pkg::*;
#(
    parameter int POS_BITS = POS_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [LIMIT_W-1:0] jump_limit,
    input  logic               up_valid,
    input  ssoi_cell_t         up_word,
    output logic               up_ready,
    output logic               dn_valid,
    output ssoi_pose_t         dn_word,
    input  logic               dn_stall
);

    localparam int AW = POS_BITS;
    localparam int WW = ((AW > POS_IN_W) ? AW : POS_IN_W) + 1;
    localparam logic [AW-1:0] PosMax = {1'b0, {(AW-1){1'b1}}};
    localparam logic [AW-1:0] PosMin = {1'b1, {(AW-1){1'b0}}};

    // Rounding stage
    logic              vr_reg;
    logic [DX_W-1:0]   dx_reg, dx_next;
    logic [DX_W-1:0]   dy_reg, dy_next;
    ssoi_tag_t         tagr_reg;

    // Accumulate stage, also the output register
    logic              va_reg;
    logic [AW-1:0]     x_acc_reg, x_acc_next;
    logic [AW-1:0]     y_acc_reg, y_acc_next;
    logic [HEAD_W-1:0] heading_reg;
    logic              jump_reg, jump_next;

    logic ra, rr;

    assign ra       = !va_reg || !dn_stall;
    assign rr       = !vr_reg || ra;
    assign up_ready = rr;

    // Add one step to an axis; returns {jump, saturated value}
    function automatic logic [AW:0] pos_step(input logic [AW-1:0] acc,
                                             input logic [DX_W-1:0] d,
                                             input logic [LIMIT_W-1:0] lim);
        logic signed [AW:0] sum, room, dw, limw;
        logic               ovf;
        logic [AW-1:0]      val;
        logic               jmp;
        dw   = $signed({{(AW+1-DX_W){d[DX_W-1]}}, d});
        sum  = $signed({acc[AW-1], acc}) + dw;
        room = $signed({1'b0, PosMax}) - $signed({acc[AW-1], acc});
        limw = $signed({{(AW+1-LIMIT_W){1'b0}}, lim});
        ovf  = sum[AW] ^ sum[AW-1];
        if (ovf)
        begin
            val = sum[AW] ? PosMin : PosMax;
            jmp = !sum[AW] && (room > limw);
        end
        else
        begin
            val = sum[AW-1:0];
            jmp = dw > limw;
        end
        return {jmp, val};
    endfunction

    // Clamp a revised position to the accumulator range
    function automatic logic [AW-1:0] rev_sat(input logic [POS_IN_W-1:0] v);
        logic signed [WW-1:0] vw, maxw, minw;
        logic [AW-1:0]        val;
        vw   = $signed({{(WW-POS_IN_W){v[POS_IN_W-1]}}, v});
        maxw = $signed({{(WW-AW){1'b0}}, PosMax});
        minw = $signed({{(WW-AW){1'b1}}, PosMin});
        if (vw > maxw)
        begin
            val = PosMax;
        end
        else if (vw < minw)
        begin
            val = PosMin;
        end
        else
        begin
            val = vw[AW-1:0];
        end
        return val;
    endfunction

    // Round half up to 2^-16 m
    always_comb
    begin
        logic signed [CORDIC_W:0] xr, yr;
        xr = $signed({up_word.x[CORDIC_W-1], up_word.x}) + (CORDIC_W+1)'(32768);
        yr = $signed({up_word.y[CORDIC_W-1], up_word.y}) + (CORDIC_W+1)'(32768);
        dx_next = xr[CORDIC_W:16];
        dy_next = yr[CORDIC_W:16];
    end

    // Accumulate or overwrite the position
    always_comb
    begin
        logic [AW:0] sx, sy;
        sx = pos_step(x_acc_reg, dx_reg, jump_limit);
        sy = pos_step(y_acc_reg, dy_reg, jump_limit);
        if (tagr_reg.rev)
        begin
            x_acc_next = rev_sat(tagr_reg.new_x);
            y_acc_next = rev_sat(tagr_reg.new_y);
            jump_next  = 1'b0;
        end
        else
        begin
            x_acc_next = sx[AW-1:0];
            y_acc_next = sy[AW-1:0];
            jump_next  = sx[AW] || sy[AW];
        end
    end

    // Valid bits and pose state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vr_reg    <= 1'b0;
            va_reg    <= 1'b0;
            x_acc_reg <= '0;
            y_acc_reg <= '0;
        end
        else
        begin
            if (rr)
            begin
                vr_reg <= up_valid;
            end
            if (ra)
            begin
                va_reg <= vr_reg;
            end
            if (ra && vr_reg)
            begin
                x_acc_reg <= x_acc_next;
                y_acc_reg <= y_acc_next;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (rr && up_valid)
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            tagr_reg <= up_word.tag;
        end
        if (ra && vr_reg)
        begin
            heading_reg <= tagr_reg.heading;
            jump_reg    <= jump_next;
        end
    end

    // Result word, low 40 bits of the sign-extended pose
    always_comb
    begin
        logic [WW-1:0] xw, yw;
        xw = {{(WW-AW){x_acc_reg[AW-1]}}, x_acc_reg};
        yw = {{(WW-AW){y_acc_reg[AW-1]}}, y_acc_reg};
        dn_word.pos_x     = xw[POS_IN_W-1:0];
        dn_word.pos_y     = yw[POS_IN_W-1:0];
        dn_word.heading   = heading_reg;
        dn_word.jump_flag = jump_reg;
    end

    assign dn_valid = va_reg;

endmodule

// ----- hw/rtl/skid_steer_odometry_integrator.sv -----
// ============================================================================
// skid_steer_odometry_integrator - dead-reckoning pose for a skid-steer base
// Wheel words move the pose through a chain of CORDIC cells; revision words
// overwrite it. One result word for every input word.
// ============================================================================
//
//  channel  | direction | handshake              | word
//  ---------+-----------+------------------------+---------------
//  sample   | in        | sample_valid/stall     | ssoi_sample_t
//  pose     | out       | pose_valid/stall       | ssoi_pose_t
//  cfg      | in        | cfg_wr_en, no wait     | cfg_index/data
//
//  One word per cycle while the pose channel is not stalled; each word passes
//  the three front stages, one cell per rotation stage and the rounding
//  and accumulate stages on its way from input to result.
//  Reset clears the pose and heading and loads the default gains and limit.
//  A pose stall holds the output register; the stall walks back through the
//  chain and empty stages keep filling until sample_stall rises.
//
module skid_steer_odometry_integrator
    import ssoi_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int POS_BITS      = POS_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 sample_valid,
    output logic                 sample_stall,
    input  ssoi_sample_t         sample,
    output logic                 pose_valid,
    input  logic                 pose_stall,
    output ssoi_pose_t           pose
);

    localparam int N     = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
    localparam int Total = N + 5;
    localparam int OccW  = $clog2(Total + 2);

    ssoi_cfg_t  cfg_reg, cfg_next;
    logic       front_ready;
    ssoi_cell_t cell_word  [0:N];
    logic       cell_valid [0:N];
    logic       cell_ready [0:N];
    logic [OccW-1:0] occ_reg, occ_next;

    // Configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TURN_GAIN:  cfg_next.turn_gain  = cfg_data[GAIN_W-1:0];
                REG_PIVOT_GAIN: cfg_next.pivot_gain = cfg_data[GAIN_W-1:0];
                REG_JUMP_LIMIT: cfg_next.jump_limit = cfg_data[LIMIT_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.turn_gain  <= TURN_GAIN_RST;
            cfg_reg.pivot_gain <= PIVOT_GAIN_RST;
            cfg_reg.jump_limit <= JUMP_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sums, heading and prescale
    ssoi_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .up_valid (sample_valid),
        .up_word  (sample),
        .up_ready (front_ready),
        .dn_valid (cell_valid[0]),
        .dn_word  (cell_word[0]),
        .dn_ready (cell_ready[0])
    );

    assign sample_stall = !front_ready;

    // Rotation chain
    for (genvar k = 0; k < N; k++)
    begin : g_cell
        ssoi_cordic_cell #(.IDX(k)) u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cell_valid[k]),
            .up_word  (cell_word[k]),
            .up_ready (cell_ready[k]),
            .dn_valid (cell_valid[k+1]),
            .dn_word  (cell_word[k+1]),
            .dn_ready (cell_ready[k+1])
        );
    end

    // Position accumulate and output register
    ssoi_pos #(.POS_BITS(POS_BITS)) u_pos
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .jump_limit (cfg_reg.jump_limit),
        .up_valid   (cell_valid[N]),
        .up_word    (cell_word[N]),
        .up_ready   (cell_ready[N]),
        .dn_valid   (pose_valid),
        .dn_word    (pose),
        .dn_stall   (pose_stall)
    );

    // Track words in flight
    always_comb
    begin
        occ_next = occ_reg;
        if (sample_valid && !sample_stall)
        begin
            occ_next = occ_next + OccW'(1);
        end
        if (pose_valid && !pose_stall)
        begin
            occ_next = occ_next - OccW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // An empty output register never blocks the input
    a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !pose_valid |-> !sample_stall)
        else $error("input stalled while output register is empty");

    // Words in flight fit in the stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OccW'(Total))
        else $error("more words in flight than pipeline stages");

    // No result without a word in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> !pose_valid)
        else $error("result shown with no word in flight");

    // A stalled input implies a full chain behind a stalled output
    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (occ_reg == OccW'(Total)) && pose_stall)
        else $error("input stalled with room in the chain");

endmodule

// ----- dv/skid_steer_odometry_integrator_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// skid_steer_odometry_integrator_test - pose integrator self-checking bench
// Drives wheel and revision words through the sample channel, predicts each
// pose word in step with the accepted input, and checks every pose word that
// leaves the block field by field. A short directed table opens the run. Six
// random segments follow under changing gains, jump limits and idle patterns.
// ============================================================================
module skid_steer_odometry_integrator_test;
    import ssoi_pkg::*;

    // Word kinds and heading rules
    localparam logic FUNC_WHEEL  = 1'b0;
    localparam logic FUNC_REVISE = 1'b1;
    localparam logic MODE_DIFF   = 1'b0;
    localparam logic MODE_PIVOT  = 1'b1;

    // Register index that maps to nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Run shape
    localparam int CORDIC_STEPS = 16;       // default stage count of the block
    localparam int PLAN_ROWS    = 23;
    localparam int SEGMENTS     = 6;
    localparam int SEG_WORDS    = 280;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 500000;

    // Position range and rotation gain
    localparam longint POS_MAX  = 64'sd549755813887;
    localparam longint POS_MIN  = -64'sd549755813888;
    localparam longint ROT_GAIN = 64'sd2608131496;

    // Field values for the directed table
    localparam logic [23:0] D0    = 24'h000000;
    localparam logic [23:0] DMAX  = 24'h7FFFFF;
    localparam logic [23:0] DMIN  = 24'h800000;
    localparam logic [23:0] DONE  = 24'h010000;
    localparam logic [23:0] DHALF = 24'h008000;
    localparam logic [23:0] DNEG  = 24'hFFFF00;
    localparam logic [23:0] DALL  = 24'hFFFFFF;
    localparam logic [39:0] P0    = 40'h00_0000_0000;
    localparam logic [39:0] PMAX  = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] PMIN  = 40'h80_0000_0000;
    localparam logic [39:0] PLOW  = 40'h80_0000_0001;
    localparam logic [39:0] PALL  = 40'hFF_FFFF_FFFF;
    localparam ssoi_pose_t  NO_POSE = '0;

    typedef struct packed {
        ssoi_sample_t word;
        logic         known;
        ssoi_pose_t   want;
    } plan_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               sample_valid = 1'b0;
    logic               sample_stall;
    ssoi_sample_t       sample = '0;
    logic               pose_valid;
    logic               pose_stall = 1'b0;
    ssoi_pose_t         pose;

    // Predicted pose and register copies
    longint      odo_x = 0;
    longint      odo_y = 0;
    logic [31:0] odo_head = 32'd0;
    longint      turn_q = 64'sd621422978;
    longint      pivot_q = 64'sd878825697;
    longint      limit_q = 64'sd6554;

    longint atan_units [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    ssoi_pose_t pending_poses [$];
    plan_row_t  plan [0:PLAN_ROWS-1];
    int         pose_errors = 0;
    int         cycle_count = 0;
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    bit         hold_req = 1'b0;
    bit         hold_taken = 1'b0;
    int         hold_left = 0;

    skid_steer_odometry_integrator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .pose_valid   (pose_valid),
        .pose_stall   (pose_stall),
        .pose         (pose)
    );

    always #10 clk = ~clk;

    // Count cycles and stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("skid_steer_odometry_integrator_test NOT OK");
            $finish;
        end
    end

    function automatic longint clamp_pos(input longint v);
        if (v > POS_MAX)
            return POS_MAX;
        if (v < POS_MIN)
            return POS_MIN;
        return v;
    endfunction

    // Advance the predicted pose by one accepted word and return the pose word
    function automatic ssoi_pose_t integrate_pose(input ssoi_sample_t w);
        ssoi_pose_t  r;
        longint      sl, sr, s, x, y, z, xs, ys, dx, dy, nx, ny, mag, prod;
        logic [31:0] dh;
        r.jump_flag = 1'b0;
        if (w.func == FUNC_REVISE)
        begin
            odo_x = clamp_pos($signed(w.new_x));
            odo_y = clamp_pos($signed(w.new_y));
            odo_head = w.new_heading;
        end
        else
        begin
            sl = $signed(w.left_front_dist) + $signed(w.left_back_dist);
            sr = $signed(w.right_front_dist) + $signed(w.right_back_dist);
            s = sl + sr;
            // Fold headings beyond a quarter turn back into range
            z = $signed(odo_head);
            if (z >= 64'sd1073741824 || z < -64'sd1073741824)
            begin
                s = -s;
                z = $signed(odo_head + 32'h8000_0000);
            end
            x = (s * ROT_GAIN) >>> 18;
            y = 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_units[i];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_units[i];
                end
            end
            dx = (x + 64'sd32768) >>> 16;
            dy = (y + 64'sd32768) >>> 16;
            nx = clamp_pos(odo_x + dx);
            ny = clamp_pos(odo_y + dy);
            if (nx - odo_x > limit_q || ny - odo_y > limit_q)
                r.jump_flag = 1'b1;
            odo_x = nx;
            odo_y = ny;
            // Turn by the pivot rule or the differential rule
            if (w.pivot_mode == MODE_PIVOT)
            begin
                mag = (sl < 0 ? -sl : sl) + (sr < 0 ? -sr : sr);
                prod = (mag * pivot_q + 64'sd65536) >>> 17;
                dh = 32'(prod);
                if (sr < 0)
                    dh = 32'd0 - dh;
            end
            else
            begin
                prod = ((sr - sl) * turn_q + 64'sd65536) >>> 17;
                dh = 32'(prod);
            end
            odo_head = odo_head + dh;
        end
        r.pos_x = 40'(odo_x);
        r.pos_y = 40'(odo_y);
        r.heading = odo_head;
        return r;
    endfunction

    function automatic logic [23:0] pick_dist();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 2))
            0:       return {{12{v[11]}}, v[11:0]};
            1:       return {{6{v[17]}}, v[17:0]};
            default: return v[23:0];
        endcase
    endfunction

    function automatic logic [39:0] pick_pos();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return v[39:0];
            1:       return PMAX - {24'd0, v[15:0]};
            2:       return PMIN + {24'd0, v[15:0]};
            default: return {{16{v[23]}}, v[23:0]};
        endcase
    endfunction

    // Write one register and mirror it in the predictor
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        case (idx)
            REG_TURN_GAIN:  turn_q = {32'd0, data};
            REG_PIVOT_GAIN: pivot_q = {32'd0, data};
            REG_JUMP_LIMIT: limit_q = {40'd0, data[23:0]};
            default:        ;
        endcase
    endtask

    // Offer one word after a random gap, hold it until taken, queue its pose
    task automatic offer_sample(input ssoi_sample_t w, input logic known,
                                input ssoi_pose_t want);
        ssoi_pose_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= w;
        do
            @(posedge clk);
        while (sample_stall);
        predicted = integrate_pose(w);
        pending_poses.push_back(known ? want : predicted);
        @(negedge clk);
    endtask

    task automatic report_miss(input string field, input logic [127:0] want,
                               input logic [127:0] got);
        pose_errors++;
        if (pose_errors <= 10)
            $display("pose mismatch on %s at cycle %0d: expected %h, got %h",
                     field, cycle_count, want, got);
    endtask

    // Stall the pose channel at random, with one long hold on request
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pose_stall <= 1'b1;
        end
        else
            pose_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Check each pose word against the oldest prediction
    always @(posedge clk)
    begin : check_pose
        ssoi_pose_t want;
        if (rst_n && pose_valid && !pose_stall)
        begin
            if (pending_poses.size() == 0)
                report_miss("word with nothing pending", '0, pose);
            else
            begin
                want = pending_poses.pop_front();
                if (pose.pos_x !== want.pos_x)
                    report_miss("pos_x", want.pos_x, pose.pos_x);
                if (pose.pos_y !== want.pos_y)
                    report_miss("pos_y", want.pos_y, pose.pos_y);
                if (pose.heading !== want.heading)
                    report_miss("heading", want.heading, pose.heading);
                if (pose.jump_flag !== want.jump_flag)
                    report_miss("jump_flag", want.jump_flag, pose.jump_flag);
            end
        end
    end

    initial
    begin
        ssoi_sample_t w;
        logic [31:0]  turn_w, pivot_w, limit_w;

        // Directed words: extremes, both heading rules, fold edges, saturation
        plan[0]  = {{FUNC_WHEEL, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'h0},
                    1'b1, {P0, P0, 32'h0, 1'b0}};
        plan[1]  = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, PMAX, PMIN, 32'h7FFF_FFFF},
                    1'b1, {PMAX, PMIN, 32'h7FFF_FFFF, 1'b0}};
        plan[2]  = {{FUNC_WHEEL, DMAX, DMAX, DMAX, DMAX, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[3]  = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, PMIN, PMAX, 32'h8000_0000},
                    1'b1, {PMIN, PMAX, 32'h8000_0000, 1'b0}};
        plan[4]  = {{FUNC_WHEEL, DMIN, DMIN, DMIN, DMIN, MODE_PIVOT, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[5]  = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'h4000_0000},
                    1'b1, {P0, P0, 32'h4000_0000, 1'b0}};
        plan[6]  = {{FUNC_WHEEL, DONE, DONE, DONE, DONE, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[7]  = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'h3FFF_FFFF},
                    1'b1, {P0, P0, 32'h3FFF_FFFF, 1'b0}};
        plan[8]  = {{FUNC_WHEEL, DONE, DONE, DONE, DONE, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[9]  = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'hC000_0000},
                    1'b1, {P0, P0, 32'hC000_0000, 1'b0}};
        plan[10] = {{FUNC_WHEEL, DONE, DONE, DONE, DONE, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[11] = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'hBFFF_FFFF},
                    1'b1, {P0, P0, 32'hBFFF_FFFF, 1'b0}};
        plan[12] = {{FUNC_WHEEL, DONE, DONE, DONE, DONE, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[13] = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, PMAX, PMAX, 32'h0},
                    1'b1, {PMAX, PMAX, 32'h0, 1'b0}};
        plan[14] = {{FUNC_WHEEL, DMAX, DMAX, DMAX, DMAX, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[15] = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'h0},
                    1'b1, {P0, P0, 32'h0, 1'b0}};
        plan[16] = {{FUNC_WHEEL, DMAX, DMAX, DMIN, DMIN, MODE_DIFF, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[17] = {{FUNC_WHEEL, DMIN, DMIN, DMAX, DMAX, MODE_PIVOT, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[18] = {{FUNC_WHEEL, DMAX, DMAX, DMIN, DMIN, MODE_PIVOT, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[19] = {{FUNC_WHEEL, DHALF, DHALF, DHALF, DHALF, MODE_DIFF, PALL, PALL,
                     32'hFFFF_FFFF}, 1'b0, NO_POSE};
        plan[20] = {{FUNC_REVISE, DALL, DALL, DALL, DALL, MODE_PIVOT, PLOW, PALL,
                     32'h0000_0001}, 1'b1, {PLOW, PALL, 32'h0000_0001, 1'b0}};
        plan[21] = {{FUNC_WHEEL, DNEG, DNEG, DNEG, DNEG, MODE_PIVOT, P0, P0, 32'h0},
                    1'b0, NO_POSE};
        plan[22] = {{FUNC_REVISE, D0, D0, D0, D0, MODE_DIFF, P0, P0, 32'h0},
                    1'b1, {P0, P0, 32'h0, 1'b0}};

        // Hold reset, then release on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Walk the directed table at reset register values
        send_idle_pct = 29;
        recv_idle_pct = 83;
        for (int r = 0; r < PLAN_ROWS; r++)
            offer_sample(plan[r].word, plan[r].known, plan[r].want);
        sample_valid <= 1'b0;

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            // Drain, then reprogram the registers while the block is idle
            while (pending_poses.size() != 0)
                @(negedge clk);
            case (seg)
                0:
                begin
                    turn_w = 32'hFFFF_FFFF;
                    pivot_w = 32'hFFFF_FFFF;
                    limit_w = 32'h0;
                end
                1:
                begin
                    turn_w = 32'h0;
                    pivot_w = 32'h0;
                    limit_w = 32'hFFFF_FFFF;
                end
                default:
                begin
                    turn_w = $urandom;
                    pivot_w = $urandom;
                    limit_w = $urandom_range(0, 1) ? $urandom_range(0, 70000) : $urandom;
                end
            endcase
            write_reg(REG_UNUSED, $urandom);
            write_reg(REG_TURN_GAIN, turn_w);
            write_reg(REG_PIVOT_GAIN, pivot_w);
            write_reg(REG_JUMP_LIMIT, limit_w);
            cfg_wr_en <= 1'b0;

            // Sender and receiver trade idle rates, then run flat out
            if (seg < 2)
            begin
                send_idle_pct = 29;
                recv_idle_pct = 83;
            end
            else if (seg < 4)
            begin
                send_idle_pct = 83;
                recv_idle_pct = 29;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg == 4)
                hold_req = 1'b1;

            // Mostly wheel words of mixed size, some pose revisions
            for (int n = 0; n < SEG_WORDS; n++)
            begin
                w.func = ($urandom_range(0, 9) == 0) ? FUNC_REVISE : FUNC_WHEEL;
                w.left_front_dist = pick_dist();
                w.left_back_dist = pick_dist();
                w.right_front_dist = pick_dist();
                w.right_back_dist = pick_dist();
                w.pivot_mode = 1'($urandom_range(0, 1));
                w.new_x = pick_pos();
                w.new_y = pick_pos();
                w.new_heading = $urandom;
                offer_sample(w, 1'b0, NO_POSE);
            end
            sample_valid <= 1'b0;
        end

        // Wait out the last words and let the pipeline settle
        while (pending_poses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pose_errors == 0)
            $display("skid_steer_odometry_integrator_test OK");
        else
            $display("skid_steer_odometry_integrator_test NOT OK");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ssoi_pkg.sv
hw/rtl/ssoi_front.sv
hw/rtl/ssoi_cordic_cell.sv
hw/rtl/ssoi_pos.sv
hw/rtl/skid_steer_odometry_integrator.sv
dv/skid_steer_odometry_integrator_test.sv
